### rtl/fds_pkg.sv
package fds_pkg;

  // Field and register widths
  localparam int BP_W       = 10;
  localparam int SPEED_W    = 10;
  localparam int NUM_W      = BP_W + SPEED_W;
  localparam int DIST_W_DEF = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_TDATA_W = ((SPEED_W + 7) / 8) * 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BP_NEAR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BP_MID     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BP_FAR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_NEAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FAR  = 3'd5;

  // Reset values
  localparam logic [BP_W-1:0]    RST_BP_NEAR    = 10'd25;
  localparam logic [BP_W-1:0]    RST_BP_MID     = 10'd38;
  localparam logic [BP_W-1:0]    RST_BP_FAR     = 10'd50;
  localparam logic [SPEED_W-1:0] RST_SPEED_NEAR = 10'd400;
  localparam logic [SPEED_W-1:0] RST_SPEED_MID  = 10'd600;
  localparam logic [SPEED_W-1:0] RST_SPEED_FAR  = 10'd800;

  typedef struct packed {
    logic [BP_W-1:0]    bp_near;
    logic [BP_W-1:0]    bp_mid;
    logic [BP_W-1:0]    bp_far;
    logic [SPEED_W-1:0] speed_near;
    logic [SPEED_W-1:0] speed_mid;
    logic [SPEED_W-1:0] speed_far;
  } cfg_t;

  // Division job handed from the front end to the divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [BP_W-1:0]  den;
    logic             fault;
  } work_t;

endpackage

### rtl/fds_front.sv
module fds_front #(
  parameter int DISTANCE_WIDTH = fds_pkg::DIST_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fds_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [DISTANCE_WIDTH-1:0] in_distance,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fds_pkg::work_t            out_work
);

  localparam int BP_W    = fds_pkg::BP_W;
  localparam int SPEED_W = fds_pkg::SPEED_W;
  localparam int NUM_W   = fds_pkg::NUM_W;
  localparam int CMP_W   = (DISTANCE_WIDTH > BP_W) ? DISTANCE_WIDTH : BP_W;

  // Stage A: segment selection
  logic               sa_valid;
  logic [SPEED_W-1:0] sa_slo, sa_shi;
  logic [BP_W-1:0]    sa_dh, sa_dl, sa_den;
  logic               sa_fault;
  // Stage B: numerator
  logic               sb_valid;
  fds_pkg::work_t     sb_work;

  logic en_a, en_b;

  logic [CMP_W-1:0]   dx, nx, mx, fx;
  logic [CMP_W-1:0]   t_dh, t_dl, t_den;
  logic               fault;
  logic [SPEED_W-1:0] slo, shi;
  logic [BP_W-1:0]    dh, dl, den;
  logic [NUM_W-1:0]   p_lo, p_hi;
  logic [NUM_W:0]     sum;

  assign en_b     = !sb_valid || out_ready;
  assign en_a     = !sa_valid || en_b;
  assign in_ready = en_a;

  assign dx = CMP_W'(in_distance);
  assign nx = CMP_W'(cfg.bp_near);
  assign mx = CMP_W'(cfg.bp_mid);
  assign fx = CMP_W'(cfg.bp_far);
  assign fault = !((nx < mx) && (mx < fx));

  // Clamp regions and faults become num = value, den = 1
  always_comb begin
    slo   = '0;
    shi   = '0;
    t_dh  = CMP_W'(1);
    t_dl  = '0;
    t_den = CMP_W'(1);
    if (fault) begin
      slo = '0;
    end else if (dx <= nx) begin
      slo = cfg.speed_near;
    end else if (dx >= fx) begin
      slo = cfg.speed_far;
    end else if (dx == mx) begin
      slo = cfg.speed_mid;
    end else if (dx < mx) begin
      slo   = cfg.speed_near;
      shi   = cfg.speed_mid;
      t_dh  = mx - dx;
      t_dl  = dx - nx;
      t_den = mx - nx;
    end else begin
      slo   = cfg.speed_mid;
      shi   = cfg.speed_far;
      t_dh  = fx - dx;
      t_dl  = dx - mx;
      t_den = fx - mx;
    end
  end

  assign dh  = t_dh[BP_W-1:0];
  assign dl  = t_dl[BP_W-1:0];
  assign den = t_den[BP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en_a) begin
      sa_valid <= in_valid;
    end
    if (en_a) begin
      sa_slo   <= slo;
      sa_shi   <= shi;
      sa_dh    <= dh;
      sa_dl    <= dl;
      sa_den   <= den;
      sa_fault <= fault;
    end
  end

  assign p_lo = sa_slo * sa_dh;
  assign p_hi = sa_shi * sa_dl;
  assign sum  = {1'b0, p_lo} + {1'b0, p_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en_b) begin
      sb_valid <= sa_valid;
    end
    if (en_b) begin
      sb_work.num   <= sum[NUM_W-1:0];
      sb_work.den   <= sa_den;
      sb_work.fault <= sa_fault;
    end
  end

  assign out_valid = sb_valid;
  assign out_work  = sb_work;

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    sb_valid |-> (sb_work.den != '0))
    else $error("division job with zero divisor");

  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    sb_valid |-> ({{SPEED_W{1'b0}}, sb_work.num} < {sb_work.den, {NUM_W{1'b0}}} >> BP_W))
    else $error("numerator too large for quotient width");

endmodule

### rtl/fds_div.sv
module fds_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fds_pkg::work_t                in_work,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fds_pkg::SPEED_W-1:0]   out_quot,
  output logic                          out_fault
);

  localparam int QW    = fds_pkg::SPEED_W;
  localparam int NUM_W = fds_pkg::NUM_W;
  localparam int BP_W  = fds_pkg::BP_W;

  // One quotient bit per stage, most significant first
  logic             v   [QW];
  logic [NUM_W-1:0] rem [QW];
  logic [BP_W-1:0]  dv  [QW];
  logic [QW-1:0]    q   [QW];
  logic             f   [QW];
  wire  [QW-1:0]    en;

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      localparam int SH = QW - 1 - k;

      logic             src_v;
      logic [NUM_W-1:0] src_rem;
      logic [BP_W-1:0]  src_den;
      logic [QW-1:0]    src_q;
      logic             src_f;
      logic [NUM_W:0]   dsh;
      logic             ge;
      logic [NUM_W:0]   diff;
      logic [QW-1:0]    q_next;

      if (k == 0) begin : g_first
        assign src_v   = in_valid;
        assign src_rem = in_work.num;
        assign src_den = in_work.den;
        assign src_q   = '0;
        assign src_f   = in_work.fault;
      end else begin : g_rest
        assign src_v   = v[k-1];
        assign src_rem = rem[k-1];
        assign src_den = dv[k-1];
        assign src_q   = q[k-1];
        assign src_f   = f[k-1];
      end

      if (k == QW - 1) begin : g_last_en
        assign en[k] = !v[k] || out_ready;
      end else begin : g_mid_en
        assign en[k] = !v[k] || en[k+1];
      end

      assign dsh  = (NUM_W + 1)'(src_den) << SH;
      assign ge   = {1'b0, src_rem} >= dsh;
      assign diff = {1'b0, src_rem} - dsh;

      always_comb begin
        q_next     = src_q;
        q_next[SH] = ge;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= src_v;
        end
        if (en[k]) begin
          rem[k] <= ge ? diff[NUM_W-1:0] : src_rem;
          dv[k]  <= src_den;
          q[k]   <= q_next;
          f[k]   <= src_f;
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[QW-1];
  assign out_quot  = q[QW-1];
  assign out_fault = f[QW-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    v[QW-1] |-> (rem[QW-1] < NUM_W'(dv[QW-1])))
    else $error("final remainder not below divisor");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (v[QW-1] && f[QW-1]) |-> (q[QW-1] == '0))
    else $error("faulted result carries nonzero speed");

endmodule

### rtl/fuzzy_distance_to_speed.sv
// Fuzzy distance-to-speed mapper. Each distance transfer on the s_ side yields
// exactly one speed transfer on the m_ side, in order. Three fuzzy sets (near,
// mid, far) each carry a breakpoint and a crisp speed, written through the cfg
// port (index 0..5: bp_near, bp_mid, bp_far, speed_near, speed_mid, speed_far;
// reset 25, 38, 50, 400, 600, 800; other indexes are ignored). At or below
// bp_near the speed is speed_near, at or above bp_far it is speed_far, at
// bp_mid it is speed_mid, and in between it is the floored linear blend of the
// two neighboring speeds. If the breakpoints are not strictly increasing,
// order_fault (tuser) is set and speed is 0. The block takes one sample per
// clock while the pipeline is not full. A sample passes a register holding the
// picked segment, one holding the two products, then the stages of the
// restoring divider, which resolves one quotient bit per stage. Every stage
// has its own valid bit and local stall, so bubbles collapse and s_tready stays
// high while a finished result waits, until the pipeline is actually full.
// Write the cfg registers only while idle.
module fuzzy_distance_to_speed #(
  parameter int DISTANCE_WIDTH = fds_pkg::DIST_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sample input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((DISTANCE_WIDTH+7)/8)*8-1:0] s_tdata,   // [DISTANCE_WIDTH-1:0] distance
  // Result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fds_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [9:0] speed
  output logic                                m_tuser,   // [0] order_fault
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fds_pkg::BP_W-1:0]            cfg_data
);

  localparam int SPEED_W = fds_pkg::SPEED_W;

  fds_pkg::cfg_t      cfg;
  fds_pkg::work_t     work;
  logic               work_valid, work_ready;
  logic [SPEED_W-1:0] quot;

  // Accept a write in every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bp_near    <= fds_pkg::RST_BP_NEAR;
      cfg.bp_mid     <= fds_pkg::RST_BP_MID;
      cfg.bp_far     <= fds_pkg::RST_BP_FAR;
      cfg.speed_near <= fds_pkg::RST_SPEED_NEAR;
      cfg.speed_mid  <= fds_pkg::RST_SPEED_MID;
      cfg.speed_far  <= fds_pkg::RST_SPEED_FAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fds_pkg::REG_BP_NEAR:    cfg.bp_near    <= cfg_data;
        fds_pkg::REG_BP_MID:     cfg.bp_mid     <= cfg_data;
        fds_pkg::REG_BP_FAR:     cfg.bp_far     <= cfg_data;
        fds_pkg::REG_SPEED_NEAR: cfg.speed_near <= cfg_data;
        fds_pkg::REG_SPEED_MID:  cfg.speed_mid  <= cfg_data;
        fds_pkg::REG_SPEED_FAR:  cfg.speed_far  <= cfg_data;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Segment selection and numerator
  fds_front #(
    .DISTANCE_WIDTH(DISTANCE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_distance(s_tdata[DISTANCE_WIDTH-1:0]),
    .out_valid  (work_valid),
    .out_ready  (work_ready),
    .out_work   (work)
  );

  // Pipelined divider; its last stage is the output register
  fds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (work_valid),
    .in_ready (work_ready),
    .in_work  (work),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_quot (quot),
    .out_fault(m_tuser)
  );

  assign m_tdata = fds_pkg::OUT_TDATA_W'(quot);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

// Fuzzy distance-to-speed mapper: stream samples in, check every speed result
// against an in-bench interpolation of the three-set curve.
module tb_top;

  localparam int IN_W       = ((fds_pkg::DIST_W_DEF + 7) / 8) * 8;
  localparam int RX_HOLD    = 300;   // long receiver hold-off, fills the pipeline
  localparam int STALL_MAX  = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN_TAIL = 20;    // wait before the final check
  localparam int NUM_CHUNKS = 12;
  localparam int CHUNK_LEN  = 42;

  // Indexes beyond the register file; writes to them must be dropped
  localparam logic [fds_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [fds_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [fds_pkg::SPEED_W-1:0] speed;
    logic                        order_fault;
  } speed_res_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [IN_W-1:0]                   s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [fds_pkg::OUT_TDATA_W-1:0]   m_tdata;
  logic                              m_tuser;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [fds_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [fds_pkg::BP_W-1:0]          cfg_data = '0;

  // Shadow of the curve registers, updated on each cfg transfer
  fds_pkg::cfg_t curve = '{fds_pkg::RST_BP_NEAR, fds_pkg::RST_BP_MID, fds_pkg::RST_BP_FAR,
                           fds_pkg::RST_SPEED_NEAR, fds_pkg::RST_SPEED_MID,
                           fds_pkg::RST_SPEED_FAR};

  logic [fds_pkg::BP_W-1:0] distance_q[$];     // samples waiting for the driver
  speed_res_t               speed_exp_q[$];    // predicted speeds, oldest first

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int          rx_hold_seq = 0;       // bump to request one receiver hold-off
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;
  int          mismatch_cnt = 0;
  int          stall_cnt = 0;

  always #4 clk = ~clk;

  fuzzy_distance_to_speed u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [9:0] distance
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [9:0] speed
    .m_tuser   (m_tuser),    // [0] order_fault
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Speed the curve gives for one distance. Between two breakpoints the
  // memberships sum to one, so the weighted average is a floored blend.
  function automatic speed_res_t interpolate_speed(logic [fds_pkg::BP_W-1:0] sample);
    speed_res_t  r;
    int unsigned d, lo, hi, s_lo, s_hi, q;
    r = '0;
    d = sample;
    if (!(curve.bp_near < curve.bp_mid && curve.bp_mid < curve.bp_far)) begin
      // Breakpoints out of order: flag it, speed forced to zero
      r.order_fault = 1'b1;
      return r;
    end
    if (d <= curve.bp_near) begin
      q = curve.speed_near;
    end else if (d >= curve.bp_far) begin
      q = curve.speed_far;
    end else if (d == curve.bp_mid) begin
      q = curve.speed_mid;
    end else begin
      if (d < curve.bp_mid) begin
        lo = curve.bp_near;  hi = curve.bp_mid;
        s_lo = curve.speed_near; s_hi = curve.speed_mid;
      end else begin
        lo = curve.bp_mid;   hi = curve.bp_far;
        s_lo = curve.speed_mid;  s_hi = curve.speed_far;
      end
      q = (s_lo * (hi - d) + s_hi * (d - lo)) / (hi - lo);
    end
    if (q > 1023) q = 1023;
    r.speed = q[fds_pkg::SPEED_W-1:0];
    return r;
  endfunction

  // Driver: predict on each accepted sample, then offer the next one unless
  // an idle cycle is drawn. Valid holds until its transfer.
  always @(posedge clk) begin : sample_driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        speed_exp_q.push_back(interpolate_speed(s_tdata[fds_pkg::BP_W-1:0]));
      if (!s_tvalid || s_tready) begin
        if (distance_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_W'(distance_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, then
  // draw the next m_tready. A hold-off request forces ready low for a stretch.
  always @(posedge clk) begin : speed_monitor
    speed_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (speed_exp_q.size() == 0) begin
        $display("%0t: result with nothing expected, got speed %0d fault %0b",
                 $time, m_tdata[fds_pkg::SPEED_W-1:0], m_tuser);
        mismatch_cnt++;
      end else begin
        want = speed_exp_q.pop_front();
        if (m_tdata[fds_pkg::SPEED_W-1:0] !== want.speed) begin
          $display("%0t: speed mismatch, expected %0d, actual %0d",
                   $time, want.speed, m_tdata[fds_pkg::SPEED_W-1:0]);
          mismatch_cnt++;
        end
        if (m_tuser !== want.order_fault) begin
          $display("%0t: order_fault mismatch, expected %0b, actual %0b",
                   $time, want.order_fault, m_tuser);
          mismatch_cnt++;
        end
      end
    end
    if (rx_hold_seq != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold_left <= RX_HOLD;
      m_tready     <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if no transfer of any kind happens for too long
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // One register write; mirror it into the shadow on the transfer
  task automatic write_reg(input logic [fds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fds_pkg::BP_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fds_pkg::REG_BP_NEAR:    curve.bp_near    = val;
      fds_pkg::REG_BP_MID:     curve.bp_mid     = val;
      fds_pkg::REG_BP_FAR:     curve.bp_far     = val;
      fds_pkg::REG_SPEED_NEAR: curve.speed_near = val;
      fds_pkg::REG_SPEED_MID:  curve.speed_mid  = val;
      fds_pkg::REG_SPEED_FAR:  curve.speed_far  = val;
      default: ;  // out of range, dropped by the block
    endcase
  endtask

  task automatic load_curve(input logic [fds_pkg::BP_W-1:0] bn, bm, bf, sn, sm, sf);
    write_reg(fds_pkg::REG_BP_NEAR, bn);
    write_reg(fds_pkg::REG_BP_MID, bm);
    write_reg(fds_pkg::REG_BP_FAR, bf);
    write_reg(fds_pkg::REG_SPEED_NEAR, sn);
    write_reg(fds_pkg::REG_SPEED_MID, sm);
    write_reg(fds_pkg::REG_SPEED_FAR, sf);
  endtask

  // Hold the stimulus until every queued sample has produced its result
  task automatic wait_idle();
    while (distance_q.size() > 0 || s_tvalid || speed_exp_q.size() > 0)
      @(posedge clk);
  endtask

  function automatic logic [fds_pkg::BP_W-1:0] draw_speed();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return fds_pkg::BP_W'($urandom_range(1023));
    endcase
  endfunction

  initial begin : stimulus
    logic [fds_pkg::BP_W-1:0] bn, bm, bf, pick;
    int                       offs;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 50;

    // Reset curve: both ends, each breakpoint and its neighbors
    distance_q = '{10'd0, 10'd24, 10'd25, 10'd26, 10'd37, 10'd38, 10'd39,
                   10'd49, 10'd50, 10'd51, 10'd1023};
    wait_idle();

    // Widest curve with extreme speeds
    load_curve(10'd0, 10'd511, 10'd1023, 10'd0, 10'd1023, 10'd0);
    distance_q = '{10'd1, 10'd510, 10'd511, 10'd512, 10'd1022};
    wait_idle();

    // Breakpoints out of order: near equals mid, mid equals far, near above mid
    load_curve(10'd5, 10'd5, 10'd9, 10'd300, 10'd400, 10'd500);
    distance_q.push_back(10'h2AA);
    wait_idle();
    write_reg(fds_pkg::REG_BP_MID, 10'd9);
    distance_q.push_back(10'h155);
    wait_idle();
    load_curve(10'd9, 10'd3, 10'd20, 10'd300, 10'd400, 10'd500);
    distance_q.push_back(10'd7);
    wait_idle();

    // Top speeds everywhere; then writes to unused indexes must change nothing
    load_curve(10'd100, 10'd200, 10'd300, 10'd1023, 10'd1023, 10'd1023);
    distance_q.push_back(10'd150);
    wait_idle();
    write_reg(REG_UNUSED_LO, 10'd0);
    write_reg(REG_UNUSED_HI, 10'h3FF);
    distance_q.push_back(10'd250);
    wait_idle();

    // Random curves, mostly well ordered, samples clustered near breakpoints
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      case (c / 4)
        0: begin tx_idle_pct = 10; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case ($urandom_range(7))
        0: begin  // tightest legal spacing
          bn = fds_pkg::BP_W'($urandom_range(1021));
          bm = bn + fds_pkg::BP_W'(1);
          bf = bn + fds_pkg::BP_W'(2);
        end
        1: begin  // out of order
          bn = fds_pkg::BP_W'($urandom_range(1023));
          bm = ($urandom_range(1)) ? bn : fds_pkg::BP_W'($urandom_range(bn));
          bf = fds_pkg::BP_W'($urandom_range(1023));
        end
        default: begin
          bn = fds_pkg::BP_W'($urandom_range(1000));
          bm = fds_pkg::BP_W'($urandom_range(1022, bn + 1));
          bf = fds_pkg::BP_W'($urandom_range(1023, bm + 1));
        end
      endcase
      load_curve(bn, bm, bf, draw_speed(), draw_speed(), draw_speed());
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  fds_pkg::BP_W'($urandom_range(1023)));
      for (int k = 0; k < CHUNK_LEN; k++) begin
        if ($urandom_range(9) < 4) begin
          case ($urandom_range(2))
            0:       pick = bn;
            1:       pick = bm;
            default: pick = bf;
          endcase
          offs = $urandom_range(4);
          distance_q.push_back(pick + fds_pkg::BP_W'(offs) - fds_pkg::BP_W'(2));
        end else begin
          distance_q.push_back(fds_pkg::BP_W'($urandom_range(1023)));
        end
      end
      // Once, stop the receiver while samples keep coming so s_tready drops
      if (c == 1)
        rx_hold_seq++;
      wait_idle();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_cnt == 0 && speed_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fds_pkg.sv
rtl/fds_front.sv
rtl/fds_div.sv
rtl/fuzzy_distance_to_speed.sv
verif/tb_top.sv
